FILE: hdl/periodic_timer_slot_table_assert.svh
// Assertion macros for the periodic timer slot table.
`ifndef PERIODIC_TIMER_SLOT_TABLE_ASSERT_SVH
`define PERIODIC_TIMER_SLOT_TABLE_ASSERT_SVH
`ifndef SYNTHESIS
`define PTS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define PTS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PTS_ASSERT(lbl, prop, msg)
`define PTS_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

FILE: hdl/pts_pkg.sv
// Shared types and constants of the periodic timer slot table.
package pts_pkg;
  localparam int SLOTS     = 16;
  localparam int NUM_SLOTS = (SLOTS < 16) ? SLOTS : 16;
  localparam int SLOT_W    = 4;
  localparam int RATE_W    = 21;
  localparam int PER_LAT   = 5;
  localparam int CNT_W     = 3;
  localparam int QUO_W     = 23;
  localparam int RECIP_SH  = 38;

  localparam logic [RATE_W-1:0] RATE_MIN     = 21'd19;
  localparam logic [RATE_W-1:0] RATE_MAX     = 21'd1193182;
  localparam logic [RATE_W-1:0] RATE_DEFAULT = 21'd1000;
  localparam logic [9:0]        MS_PER_S     = 10'd1000;
  // ceil(2^38 / 1000): exact floor(x / 1000) for any 32-bit x
  localparam logic [28:0]       RECIP_1000   = 29'd274877907;

  localparam logic [1:0] CMD_TICK   = 2'd0;
  localparam logic [1:0] CMD_REG    = 2'd1;
  localparam logic [1:0] CMD_UNREG  = 2'd2;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  localparam logic [1:0] KIND_FIRED = 2'd0;
  localparam logic [1:0] KIND_REG   = 2'd1;
  localparam logic [1:0] KIND_UNREG = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WALK,
    ST_DIV,
    ST_EMIT,
    ST_REPLY
  } state_t;

  typedef struct packed {
    logic        active;
    logic [15:0] handle;
    logic [31:0] tag;
    logic [31:0] interval;
    logic [63:0] due;
  } slot_t;
endpackage

FILE: hdl/pts_in_if.sv
// Input channel: command items.
interface pts_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [15:0] handle;
  logic [31:0] client_tag;
  logic [31:0] period_ms;
  modport source (output valid, command, handle, client_tag, period_ms, input ready);
  modport sink (input valid, command, handle, client_tag, period_ms, output ready);
endinterface

FILE: hdl/pts_out_if.sv
// Output channel: fire events and command replies.
interface pts_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic        ok;
  logic [3:0]  slot;
  logic [15:0] fired_handle;
  logic [31:0] fired_tag;
  logic [63:0] tick_now;
  logic        last;
  modport source (output valid, kind, ok, slot, fired_handle, fired_tag, tick_now, last,
                  input ready);
  modport sink (input valid, kind, ok, slot, fired_handle, fired_tag, tick_now, last,
                output ready);
endinterface

FILE: hdl/pts_cell.sv
// One slot cell of the rotating slot ring.
module pts_cell (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              shift_en,
  input  pts_pkg::slot_t    d,
  input  logic [63:0]       tick_now,
  output pts_pkg::slot_t    q,
  output logic              due_ok
);
  logic        active_r;
  logic [15:0] handle_r;
  logic [31:0] tag_r;
  logic [31:0] interval_r;
  logic [63:0] due_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
    end else if (shift_en) begin
      active_r <= d.active;
    end
  end

  always_ff @(posedge clk) begin
    if (shift_en) begin
      handle_r   <= d.handle;
      tag_r      <= d.tag;
      interval_r <= d.interval;
      due_r      <= d.due;
    end
  end

  assign q      = '{active: active_r, handle: handle_r, tag: tag_r,
                    interval: interval_r, due: due_r};
  assign due_ok = active_r && (tick_now >= due_r);
endmodule

FILE: hdl/pts_period.sv
// Period unit: ms * rate / 1000 in ticks, floor at one, by reciprocal multiplication.
module pts_period (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [31:0]                  ms,
  input  logic [pts_pkg::RATE_W-1:0]   rate,
  output logic                         busy,
  output logic                         done,
  output logic [63:0]                  ticks
);
  logic                         busy_r;
  logic                         done_r;
  logic [pts_pkg::CNT_W-1:0]    cnt_r;
  logic [31:0]                  ms_r;
  logic [pts_pkg::RATE_W-1:0]   rate_r;
  logic [pts_pkg::QUO_W-1:0]    q1_r;
  logic [9:0]                   r1_r;
  logic [43:0]                  qr_r;
  logic [30:0]                  t_r;
  logic [pts_pkg::QUO_W-1:0]    f_r;
  logic [43:0]                  sum_r;
  logic [60:0]                  q1_prod;
  logic [60:0]                  f_prod;

  // ms*rate/1000 = (ms/1000)*rate + ((ms%1000)*rate)/1000, one step a cycle
  assign q1_prod = 61'(ms_r) * 61'(pts_pkg::RECIP_1000);
  assign f_prod  = 61'(t_r) * 61'(pts_pkg::RECIP_1000);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start && !busy_r) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == pts_pkg::CNT_W'(pts_pkg::PER_LAT - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy_r) begin
      ms_r   <= ms;
      rate_r <= rate;
    end else if (busy_r) begin
      q1_r  <= q1_prod[pts_pkg::RECIP_SH +: pts_pkg::QUO_W];
      r1_r  <= 10'(ms_r - 32'(q1_r) * 32'(pts_pkg::MS_PER_S));
      qr_r  <= 44'(q1_r) * 44'(rate_r);
      t_r   <= 31'(r1_r) * 31'(rate_r);
      f_r   <= f_prod[pts_pkg::RECIP_SH +: pts_pkg::QUO_W];
      sum_r <= qr_r + 44'(f_r);
    end
  end

  assign busy  = busy_r;
  assign done  = done_r;
  assign ticks = (sum_r == '0) ? 64'd1 : 64'(sum_r);
endmodule

FILE: hdl/periodic_timer_slot_table.sv
// Top level: slot ring, walk sequencer, period unit and result register.
// An item is accepted, then the ring is walked one slot a cycle unless the walk is held.
// A failed register or unregister adds a reply state. Every fired slot and a successful
// register hold the walk for the period unit (start, multiply steps, done).
// One item at a time; a result waits in the output register, output stalls stretch the walk.
// Synchronous active-low reset clears tick count, slot active bits; rate returns to 1000.
`include "periodic_timer_slot_table_assert.svh"
module periodic_timer_slot_table (
  input  logic                        clk,
  input  logic                        rst_n,
  pts_in_if.sink                      in_ch,
  pts_out_if.source                   out_ch,
  input  logic                        cfg_we,
  input  logic [pts_pkg::RATE_W-1:0]  cfg_wdata
);
  pts_pkg::state_t state_r, state_nxt;
  logic [pts_pkg::SLOT_W-1:0] step_r, step_nxt;
  logic [1:0]   cmd_r;
  logic [15:0]  hd_r;
  logic [31:0]  tag_r;
  logic [31:0]  ms_r;
  logic [63:0]  tick_r;
  logic         found_r, found_nxt;
  logic [pts_pkg::RATE_W-1:0] rate_r;

  logic         out_valid_r;
  logic [1:0]   o_kind_r;
  logic         o_ok_r;
  logic [3:0]   o_slot_r;
  logic [15:0]  o_handle_r;
  logic [31:0]  o_tag_r;
  logic [63:0]  o_tick_r;
  logic         o_last_r;

  pts_pkg::slot_t cq [pts_pkg::NUM_SLOTS];
  pts_pkg::slot_t cd [pts_pkg::NUM_SLOTS];
  logic [pts_pkg::NUM_SLOTS-1:0] due_vec;
  pts_pkg::slot_t head, wb;

  logic        rot, emit, per_start, per_busy, per_done;
  logic [63:0] per_ticks;
  logic [31:0] per_ms;
  logic        out_free, later_due, last_step, is_tick, is_reg, is_unr;
  logic        need_per, unr_hit, accept;
  logic [1:0]  em_kind;
  logic        em_ok, em_last;
  logic [3:0]  em_slot;
  logic [15:0] em_handle;
  logic [31:0] em_tag;

  assign head      = cq[0];
  assign out_free  = !out_valid_r || out_ch.ready;
  assign is_tick   = cmd_r == pts_pkg::CMD_TICK;
  assign is_reg    = cmd_r == pts_pkg::CMD_REG;
  assign is_unr    = cmd_r == pts_pkg::CMD_UNREG;
  assign last_step = step_r == pts_pkg::SLOT_W'(pts_pkg::NUM_SLOTS - 1);
  assign accept    = in_ch.valid && in_ch.ready;
  assign in_ch.ready = state_r == pts_pkg::ST_IDLE;

  assign need_per = (is_tick && due_vec[0]) ||
                    (is_reg && !found_r && !head.active && hd_r != '0 && ms_r != '0);
  assign unr_hit  = is_unr && !found_r && head.active && head.handle == hd_r && hd_r != '0;
  assign per_ms   = is_tick ? head.interval : ms_r;

  // slots not yet visited sit at ring positions 1 .. NUM_SLOTS-1-step
  always_comb begin
    later_due = 1'b0;
    for (int k = 1; k < pts_pkg::NUM_SLOTS; k++) begin
      if (k + int'(step_r) <= pts_pkg::NUM_SLOTS - 1) begin
        later_due = later_due | due_vec[k];
      end
    end
  end

  // ring: each cell takes its neighbor, the last takes the written-back head
  for (genvar g = 0; g < pts_pkg::NUM_SLOTS; g++) begin : g_ring
    if (g == pts_pkg::NUM_SLOTS - 1) begin : g_tail
      assign cd[g] = wb;
    end else begin : g_mid
      assign cd[g] = cq[g+1];
    end
    pts_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .shift_en (rot),
      .d        (cd[g]),
      .tick_now (tick_r),
      .q        (cq[g]),
      .due_ok   (due_vec[g])
    );
  end

  pts_period u_period (
    .clk   (clk),
    .rst_n (rst_n),
    .start (per_start),
    .ms    (per_ms),
    .rate  (rate_r),
    .busy  (per_busy),
    .done  (per_done),
    .ticks (per_ticks)
  );

  // control outputs of the walk
  always_comb begin
    rot       = 1'b0;
    emit      = 1'b0;
    per_start = 1'b0;
    found_nxt = found_r;
    wb        = head;
    em_kind   = cmd_r;
    em_ok     = 1'b1;
    em_slot   = 4'(step_r);
    em_handle = head.handle;
    em_tag    = head.tag;
    em_last   = 1'b1;
    case (state_r)
      pts_pkg::ST_WALK: begin
        if (need_per) begin
          per_start = 1'b1;
        end else if (unr_hit) begin
          if (out_free) begin
            emit      = 1'b1;
            rot       = 1'b1;
            found_nxt = 1'b1;
            wb.active = 1'b0;
          end
        end else begin
          rot = 1'b1;
        end
      end
      pts_pkg::ST_EMIT: begin
        if (out_free) begin
          emit = 1'b1;
          rot  = 1'b1;
          if (is_tick) begin
            em_kind = pts_pkg::KIND_FIRED;
            em_last = !later_due;
            wb.due  = tick_r + per_ticks;
          end else begin
            em_handle = hd_r;
            em_tag    = tag_r;
            found_nxt = 1'b1;
            wb        = '{active: 1'b1, handle: hd_r, tag: tag_r, interval: ms_r,
                          due: tick_r + per_ticks};
          end
        end
      end
      pts_pkg::ST_REPLY: begin
        if (out_free) begin
          emit      = 1'b1;
          em_ok     = 1'b0;
          em_slot   = '0;
          em_handle = '0;
          em_tag    = '0;
        end
      end
      default: begin
      end
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    case (state_r)
      pts_pkg::ST_IDLE: begin
        if (accept && in_ch.command != pts_pkg::CMD_UNUSED) begin
          state_nxt = pts_pkg::ST_WALK;
        end
      end
      pts_pkg::ST_WALK, pts_pkg::ST_EMIT: begin
        if (state_r == pts_pkg::ST_WALK && need_per) begin
          state_nxt = pts_pkg::ST_DIV;
        end else if (rot) begin
          if (last_step) begin
            step_nxt  = '0;
            state_nxt = (!is_tick && !found_nxt) ? pts_pkg::ST_REPLY : pts_pkg::ST_IDLE;
          end else begin
            step_nxt  = step_r + 1'b1;
            state_nxt = pts_pkg::ST_WALK;
          end
        end
      end
      pts_pkg::ST_DIV: begin
        if (per_done) begin
          state_nxt = pts_pkg::ST_EMIT;
        end
      end
      pts_pkg::ST_REPLY: begin
        if (emit) begin
          state_nxt = pts_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = pts_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pts_pkg::ST_IDLE;
      step_r  <= '0;
      found_r <= 1'b0;
      tick_r  <= '0;
      rate_r  <= pts_pkg::RATE_DEFAULT;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      found_r <= accept ? 1'b0 : found_nxt;
      if (accept && in_ch.command == pts_pkg::CMD_TICK) begin
        tick_r <= tick_r + 64'd1;
      end
      if (cfg_we) begin
        rate_r <= (cfg_wdata < pts_pkg::RATE_MIN || cfg_wdata > pts_pkg::RATE_MAX) ?
                  pts_pkg::RATE_DEFAULT : cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r <= in_ch.command;
      hd_r  <= in_ch.handle;
      tag_r <= in_ch.client_tag;
      ms_r  <= in_ch.period_ms;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      o_kind_r   <= em_kind;
      o_ok_r     <= em_ok;
      o_slot_r   <= em_slot;
      o_handle_r <= em_handle;
      o_tag_r    <= em_tag;
      o_tick_r   <= tick_r;
      o_last_r   <= em_last;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.kind         = o_kind_r;
  assign out_ch.ok           = o_ok_r;
  assign out_ch.slot         = o_slot_r;
  assign out_ch.fired_handle = o_handle_r;
  assign out_ch.fired_tag    = o_tag_r;
  assign out_ch.tick_now     = o_tick_r;
  assign out_ch.last         = o_last_r;

  `PTS_ASSERT(a_idle_step_zero, (state_r == pts_pkg::ST_IDLE) |-> (step_r == '0), "idle step")
  `PTS_ASSERT(a_no_rot_while_div, rot |-> !per_busy, "ring rotated during period computation")
  `PTS_ASSERT(a_done_in_div, per_done |-> (state_r == pts_pkg::ST_DIV), "period done outside wait")
  `PTS_ASSERT_ALWAYS(a_reset_idle, !rst_n |=> (state_r == pts_pkg::ST_IDLE && !out_valid_r), "reset")
endmodule
